@@ rtl/spcd_pkg.sv @@
package spcd_pkg;

    // Width of the distance and clearance results, unsigned Q13.8.
    localparam int OUT_BITS = 21;

    typedef logic [OUT_BITS-1:0] out_word_t;

    // Largest result value; distances above it saturate here.
    localparam out_word_t OUT_MAX = '1;

endpackage

@@ rtl/sphere_pair_clearance_distance.sv @@
// Sphere pair clearance distance, fully pipelined.
//
// The item channel (item_valid, item_stall) carries two spheres: signed
// centers first_x..first_z and second_x..second_z, and unsigned radii
// first_radius and second_radius, all with the same fraction bits. Each
// transfer yields exactly one transfer on the result channel (result_valid,
// result_stall) with center_distance, clearance and overlapping.
// The pipeline has COORD_BITS + 5 register stages: one for the coordinate
// differences, one for the squares, one for the sum, one per root bit of
// the square root (COORD_BITS + 1 stages, each a single wide compare and
// subtract), and one for the clearance and saturation.
// One item can be taken in every cycle while item_stall is low. When the
// receiver raises result_stall, the result register holds and stages fill
// up behind it; item_stall rises only once every stage holds a live item.
// The planar_mode register is written through config_write and config_data;
// the user must write it only while the block is idle, which the block itself
// does not enforce. Reset clears planar_mode and all valid bits.
module sphere_pair_clearance_distance #(
    parameter int COORD_BITS = 20
) (
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         config_write,
    input  logic                         config_data,

    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic signed [COORD_BITS-1:0] first_x,
    input  logic signed [COORD_BITS-1:0] first_y,
    input  logic signed [COORD_BITS-1:0] first_z,
    input  logic        [COORD_BITS-2:0] first_radius,
    input  logic signed [COORD_BITS-1:0] second_x,
    input  logic signed [COORD_BITS-1:0] second_y,
    input  logic signed [COORD_BITS-1:0] second_z,
    input  logic        [COORD_BITS-2:0] second_radius,

    output logic                         result_valid,
    input  logic                         result_stall,
    output spcd_pkg::out_word_t          center_distance,
    output spcd_pkg::out_word_t          clearance,
    output logic                         overlapping
);
    import spcd_pkg::*;

    // A coordinate difference has magnitude below 2^COORD_BITS, so its
    // square fits in 2*COORD_BITS bits and three of them in two more bits.
    localparam int D_W    = COORD_BITS + 1;
    localparam int MAG_W  = COORD_BITS;
    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int SUM_W  = 2 * COORD_BITS + 2;
    localparam int ROOT_W = COORD_BITS + 1;
    localparam int NSTAGE = ROOT_W + 4;
    localparam int EXT_W  = (ROOT_W > OUT_BITS) ? ROOT_W : OUT_BITS;

    logic planar_mode_reg;

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] stage_ready;

    logic [MAG_W-1:0]  mag_x_reg, mag_y_reg, mag_z_reg;
    logic [SQ_W-1:0]   sq_x_reg, sq_y_reg, sq_z_reg;
    logic [SUM_W-1:0]  rem_reg  [ROOT_W+1];
    logic [ROOT_W-1:0] root_reg [ROOT_W+1];
    logic [MAG_W-1:0]  rsum_reg [NSTAGE-1];

    out_word_t center_distance_reg;
    out_word_t clearance_reg;
    logic      overlapping_reg;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            planar_mode_reg <= 1'b0;
        end
        else if (config_write)
        begin
            planar_mode_reg <= config_data;
        end
    end

    // A stage loads when it is empty or its content moves on in the same
    // cycle, so bubbles are squeezed out behind a stalled result.
    assign stage_ready[NSTAGE-1] = !valid_reg[NSTAGE-1] || !result_stall;

    genvar g;
    generate
        for (g = 0; g < NSTAGE - 1; g++)
        begin : g_ready
            assign stage_ready[g] = !valid_reg[g] || stage_ready[g+1];
        end
    endgenerate

    assign item_stall = !stage_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_ready[0])
            begin
                valid_reg[0] <= item_valid;
            end
            for (int k = 1; k < NSTAGE; k++)
            begin
                if (stage_ready[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Stage 0: coordinate differences and their magnitudes. In planar mode
    // the z difference is forced to zero.
    logic signed [D_W-1:0] dx, dy, dz;
    logic [MAG_W-1:0]      mag_x_next, mag_y_next, mag_z_next;
    logic [MAG_W-1:0]      rsum_next;

    always_comb
    begin
        dx = D_W'(first_x) - D_W'(second_x);
        dy = D_W'(first_y) - D_W'(second_y);
        dz = D_W'(first_z) - D_W'(second_z);
        mag_x_next = dx[D_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
        mag_y_next = dy[D_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
        mag_z_next = dz[D_W-1] ? MAG_W'(-dz) : MAG_W'(dz);
        if (planar_mode_reg)
        begin
            mag_z_next = '0;
        end
        rsum_next = MAG_W'(first_radius) + MAG_W'(second_radius);
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[0])
        begin
            mag_x_reg   <= mag_x_next;
            mag_y_reg   <= mag_y_next;
            mag_z_reg   <= mag_z_next;
            rsum_reg[0] <= rsum_next;
        end
    end

    // Stage 1: squares. Stage 2: their sum, which seeds the root search.
    always_ff @(posedge clk)
    begin
        if (stage_ready[1])
        begin
            sq_x_reg    <= SQ_W'(mag_x_reg) * SQ_W'(mag_x_reg);
            sq_y_reg    <= SQ_W'(mag_y_reg) * SQ_W'(mag_y_reg);
            sq_z_reg    <= SQ_W'(mag_z_reg) * SQ_W'(mag_z_reg);
            rsum_reg[1] <= rsum_reg[0];
        end
        if (stage_ready[2])
        begin
            rem_reg[0]  <= SUM_W'(sq_x_reg) + SUM_W'(sq_y_reg) + SUM_W'(sq_z_reg);
            root_reg[0] <= '0;
            rsum_reg[2] <= rsum_reg[1];
        end
    end

    // Square root, one result bit per stage from the top. With the upper
    // root bits r already settled and rem = sum - r^2, setting bit b adds
    // (r << (b+1)) + 4^b to the square; the bit is kept when that fits.
    generate
        for (g = 0; g < ROOT_W; g++)
        begin : g_root
            localparam int BIT = ROOT_W - 1 - g;
            logic [SUM_W-1:0] trial;
            logic             fits;

            assign trial = (SUM_W'(root_reg[g]) << (BIT + 1)) + (SUM_W'(1) << (2 * BIT));
            assign fits  = (rem_reg[g] >= trial);

            always_ff @(posedge clk)
            begin
                if (stage_ready[3+g])
                begin
                    rem_reg[g+1]  <= fits ? (rem_reg[g] - trial) : rem_reg[g];
                    root_reg[g+1] <= fits ? (root_reg[g] | (ROOT_W'(1) << BIT))
                                          : root_reg[g];
                    rsum_reg[3+g] <= rsum_reg[2+g];
                end
            end
        end
    endgenerate

    // Last stage: clearance from the floored distance, then saturation of
    // both values to the result width.
    logic [ROOT_W-1:0] root_dist;
    logic [ROOT_W-1:0] rsum_wide;
    logic [ROOT_W-1:0] clr;
    logic [EXT_W-1:0]  dist_ext, clr_ext;
    out_word_t         dist_sat, clr_sat;

    always_comb
    begin
        root_dist = root_reg[ROOT_W];
        rsum_wide = ROOT_W'(rsum_reg[NSTAGE-2]);
        clr       = (root_dist > rsum_wide) ? (root_dist - rsum_wide) : '0;
        dist_ext  = EXT_W'(root_dist);
        clr_ext   = EXT_W'(clr);
        dist_sat  = (dist_ext > EXT_W'(OUT_MAX)) ? OUT_MAX : OUT_BITS'(dist_ext);
        clr_sat   = (clr_ext > EXT_W'(OUT_MAX)) ? OUT_MAX : OUT_BITS'(clr_ext);
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[NSTAGE-1])
        begin
            center_distance_reg <= dist_sat;
            clearance_reg       <= clr_sat;
            overlapping_reg     <= (clr == '0);
        end
    end

    assign result_valid    = valid_reg[NSTAGE-1];
    assign center_distance = center_distance_reg;
    assign clearance       = clearance_reg;
    assign overlapping     = overlapping_reg;

endmodule

@@ rtl/spcd_checker.sv @@
module spcd_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                item_stall,
    input logic                result_valid,
    input logic                result_stall,
    input spcd_pkg::out_word_t center_distance,
    input spcd_pkg::out_word_t clearance,
    input logic                overlapping
);
    import spcd_pkg::*;

    // A stalled result stays offered with the same values.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(center_distance)
            && $stable(clearance) && $stable(overlapping))
        else $error("stalled result changed");

    // The overlap flag reports exactly a zero clearance.
    a_overlap_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (overlapping == (clearance == '0)))
        else $error("overlap flag disagrees with clearance");

    // Removing the radii never increases the distance.
    a_clearance_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (clearance <= center_distance))
        else $error("clearance exceeds center distance");

    // With the result side free the pipeline always moves, so items flow.
    a_no_input_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !result_stall |-> !item_stall)
        else $error("item stalled while result channel is free");

endmodule

bind sphere_pair_clearance_distance spcd_checker u_spcd_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_stall      (item_stall),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .center_distance (center_distance),
    .clearance       (clearance),
    .overlapping     (overlapping)
);

@@ bench/tb_sphere_pair_clearance_distance.sv @@
module tb_sphere_pair_clearance_distance;
    timeunit 1ns;
    timeprecision 1ps;

    import spcd_pkg::*;

    // The bench runs the block at its default width, Q12.8 coordinates.
    localparam int COORD_BITS = 20;

    // Cycles without any transfer on either channel before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;

    // Quiet cycles after the last result, so that a stray result still
    // leaving the pipeline would be caught by the result checker.
    localparam int DRAIN_CYCLES = COORD_BITS + 20;

    localparam int MAX_REPORTS = 10;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic        [COORD_BITS-2:0] radius_t;

    localparam coord_t  COORD_MIN  = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam coord_t  COORD_MAX  = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam radius_t RADIUS_MAX = '1;

    // One item: two spheres, each a center and a radius.
    typedef struct {
        coord_t  first_x, first_y, first_z;
        radius_t first_radius;
        coord_t  second_x, second_y, second_z;
        radius_t second_radius;
    } sphere_pair_t;

    // One result, compared as a whole but reported field by field.
    typedef struct packed {
        out_word_t center_distance;
        out_word_t clearance;
        logic      overlapping;
    } clearance_result_t;

    logic      clk;
    logic      rst_n;
    logic      config_write;
    logic      config_data;
    logic      item_valid;
    logic      item_stall;
    coord_t    first_x, first_y, first_z;
    radius_t   first_radius;
    coord_t    second_x, second_y, second_z;
    radius_t   second_radius;
    logic      result_valid;
    logic      result_stall;
    out_word_t center_distance;
    out_word_t clearance;
    logic      overlapping;

    // Pairs waiting to be driven, and the results that accepted pairs owe.
    sphere_pair_t      pairs_to_send[$];
    clearance_result_t owed_results[$];

    // The pair currently presented on the item channel.
    sphere_pair_t on_wire;

    // Mirror of the planar_mode register, updated on each write.
    logic planar_model = 1'b0;

    // Percentage of cycles in which each side holds back.
    int idle_pct = 30;

    logic item_taken   = 1'b0;
    int   queued_count = 0;
    int   accepted_count = 0;
    int   results_seen = 0;
    int   mismatches   = 0;
    int   stuck_cycles = 0;

    sphere_pair_clearance_distance #(
        .COORD_BITS(COORD_BITS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .config_write   (config_write),
        .config_data    (config_data),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .first_x        (first_x),
        .first_y        (first_y),
        .first_z        (first_z),
        .first_radius   (first_radius),
        .second_x       (second_x),
        .second_y       (second_y),
        .second_z       (second_z),
        .second_radius  (second_radius),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .center_distance(center_distance),
        .clearance      (clearance),
        .overlapping    (overlapping)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Predicts the result of one pair. The squared distance needs about
    // 42 bits, so the arithmetic is done in 64-bit integers. The root is
    // found one bit at a time from the top: a bit is kept when the square
    // of the partial root still fits under the sum, which yields the floor.
    // The radii are then taken off the floored distance, so a clearance
    // smaller than one LSB reads as zero and counts as overlap.
    function automatic clearance_result_t sphere_clearance(sphere_pair_t p, logic planar);
        longint dx, dy, dz, sq_sum, root, trial, reach, gap;
        clearance_result_t r;
        dx = longint'(p.first_x) - longint'(p.second_x);
        dy = longint'(p.first_y) - longint'(p.second_y);
        dz = longint'(p.first_z) - longint'(p.second_z);
        sq_sum = dx * dx + dy * dy;
        if (!planar)
            sq_sum += dz * dz;
        root = 0;
        for (int b = OUT_BITS; b >= 0; b--)
        begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= sq_sum)
                root = trial;
        end
        reach = longint'(p.first_radius) + longint'(p.second_radius);
        gap = (root > reach) ? root - reach : 0;
        // Saturation cannot occur at this width, but is kept for safety.
        if (root > longint'(OUT_MAX))
            root = longint'(OUT_MAX);
        if (gap > longint'(OUT_MAX))
            gap = longint'(OUT_MAX);
        r.center_distance = out_word_t'(root);
        r.clearance       = out_word_t'(gap);
        r.overlapping     = (gap == 0);
        return r;
    endfunction

    // Picks radii whose sum lands within a few LSBs of the center distance where the
    // radius range allows, so that touching, barely overlapping and barely clear pairs are common.
    function automatic sphere_pair_t with_touching_radii(sphere_pair_t p);
        clearance_result_t apart;
        int reach, lo, hi, part;
        apart = sphere_clearance(p, planar_model);
        reach = int'(apart.center_distance) + int'($urandom_range(8)) - 4;
        if (reach < 0)
            reach = 0;
        if (reach > 2 * int'(RADIUS_MAX))
            reach = 2 * int'(RADIUS_MAX);
        lo = (reach > int'(RADIUS_MAX)) ? reach - int'(RADIUS_MAX) : 0;
        hi = (reach < int'(RADIUS_MAX)) ? reach : int'(RADIUS_MAX);
        part = $urandom_range(hi, lo);
        p.first_radius  = radius_t'(part);
        p.second_radius = radius_t'(reach - part);
        return p;
    endfunction

    function automatic coord_t nudge(coord_t c, int span);
        return c + coord_t'(int'($urandom_range(2 * span)) - span);
    endfunction

    function automatic coord_t pick_extreme_coord();
        case ($urandom_range(4))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return '0;
            3:       return '1;
            default: return coord_t'($urandom());
        endcase
    endfunction

    // Random pairs come in four kinds: fully random fields; nearby centers
    // with radii that almost exactly bridge the gap; distant centers with
    // such radii; and coordinates mostly, radii at times, drawn from the range limits.
    function automatic sphere_pair_t random_pair();
        sphere_pair_t p;
        int kind, span;
        kind = $urandom_range(99);
        p.first_x       = coord_t'($urandom());
        p.first_y       = coord_t'($urandom());
        p.first_z       = coord_t'($urandom());
        p.first_radius  = radius_t'($urandom());
        p.second_x      = coord_t'($urandom());
        p.second_y      = coord_t'($urandom());
        p.second_z      = coord_t'($urandom());
        p.second_radius = radius_t'($urandom());
        if (kind < 35)
            return p;
        if (kind < 65)
        begin
            span = 1 << $urandom_range(12);
            p.second_x = nudge(p.first_x, span);
            p.second_y = nudge(p.first_y, span);
            p.second_z = nudge(p.first_z, span);
            return with_touching_radii(p);
        end
        if (kind < 80)
            return with_touching_radii(p);
        p.first_x  = pick_extreme_coord();
        p.first_y  = pick_extreme_coord();
        p.first_z  = pick_extreme_coord();
        p.second_x = pick_extreme_coord();
        p.second_y = pick_extreme_coord();
        p.second_z = pick_extreme_coord();
        if ($urandom_range(2) == 0)
            p.first_radius = $urandom_range(1) ? RADIUS_MAX : '0;
        if ($urandom_range(2) == 0)
            p.second_radius = $urandom_range(1) ? RADIUS_MAX : '0;
        return p;
    endfunction

    task automatic queue_pair(sphere_pair_t p);
        pairs_to_send = {pairs_to_send, p};
        queued_count++;
    endtask

    task automatic send_pair(coord_t fx, coord_t fy, coord_t fz, radius_t fr,
                             coord_t sx, coord_t sy, coord_t sz, radius_t sr);
        sphere_pair_t p;
        p = '{fx, fy, fz, fr, sx, sy, sz, sr};
        queue_pair(p);
    endtask

    // Blocks until every queued pair has been accepted and every result it
    // owes has come back. Each pair yields exactly one result, so an empty
    // store of owed results means that the pipeline is empty as well.
    task automatic finish_phase();
        while (accepted_count != queued_count || owed_results.size() != 0)
            @(negedge clk);
    endtask

    // The register is only written while the pipeline is empty.
    task automatic set_planar(logic mode);
        @(negedge clk);
        config_write <= 1'b1;
        config_data  <= mode;
        @(negedge clk);
        config_write <= 1'b0;
        planar_model = mode;
    endtask

    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // Item driver. A new pair is presented only once the previous one has
    // been transferred (or none was presented), so a stalled payload stays
    // put. The decision to hold back never looks at item_stall. The result
    // side stalls at random at the same rate.
    always @(negedge clk)
    begin
        if (rst_n && (!item_valid || item_taken))
        begin
            if (pairs_to_send.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                on_wire = pairs_to_send.pop_front();
                first_x       <= on_wire.first_x;
                first_y       <= on_wire.first_y;
                first_z       <= on_wire.first_z;
                first_radius  <= on_wire.first_radius;
                second_x      <= on_wire.second_x;
                second_y      <= on_wire.second_y;
                second_z      <= on_wire.second_z;
                second_radius <= on_wire.second_radius;
                item_valid    <= 1'b1;
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
        result_stall <= ($urandom_range(99) < idle_pct);
    end

    // Monitor. At each rising edge it records an item transfer together with
    // its predicted result, and checks a result transfer against the oldest
    // prediction. It also keeps the count of cycles without any transfer.
    always @(posedge clk)
    begin
        clearance_result_t want, got;
        item_taken <= item_valid && !item_stall;
        if (item_valid && !item_stall)
        begin
            owed_results = {owed_results, sphere_clearance(on_wire, planar_model)};
            accepted_count++;
        end
        if (result_valid && !result_stall)
        begin
            got = '{center_distance, clearance, overlapping};
            if (owed_results.size() == 0)
            begin
                report_mismatch($sformatf(
                    "unexpected result distance %0d clearance %0d overlap %0d",
                    got.center_distance, got.clearance, got.overlapping));
            end
            else
            begin
                want = owed_results.pop_front();
                if (got !== want)
                    report_mismatch($sformatf(
                        "result %0d: distance %0d/%0d clearance %0d/%0d overlap %0d/%0d (exp/act)",
                        results_seen, want.center_distance, got.center_distance,
                        want.clearance, got.clearance, want.overlapping, got.overlapping));
            end
            results_seen++;
        end
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    // Watchdog: ends a run in which the channels have stopped moving.
    initial
    begin
        wait (stuck_cycles >= WATCHDOG_LIMIT);
        $display("FAIL sphere_pair_clearance_distance");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        config_write  = 1'b0;
        config_data   = 1'b0;
        item_valid    = 1'b0;
        result_stall  = 1'b0;
        first_x       = '0;
        first_y       = '0;
        first_z       = '0;
        first_radius  = '0;
        second_x      = '0;
        second_y      = '0;
        second_z      = '0;
        second_radius = '0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed pairs in three dimensions. Identical centers come first,
        // then the largest separations along all axes and along x or z
        // alone, then exact touching, a clearance of one LSB, a clearance
        // below one LSB that floors to zero, and a bit pattern that toggles
        // every input bit.
        set_planar(1'b0);
        send_pair(0, 0, 0, 0, 0, 0, 0, 0);
        send_pair(-77, 1234, -5, RADIUS_MAX, -77, 1234, -5, RADIUS_MAX);
        send_pair(COORD_MAX, COORD_MAX, COORD_MAX, 0, COORD_MIN, COORD_MIN, COORD_MIN, 0);
        send_pair(COORD_MIN, COORD_MIN, COORD_MIN, RADIUS_MAX,
                  COORD_MAX, COORD_MAX, COORD_MAX, RADIUS_MAX);
        // Distance 1048575 against radii summing to 1048574 leaves one LSB.
        send_pair(COORD_MAX, 0, 0, RADIUS_MAX, COORD_MIN, 0, 0, RADIUS_MAX);
        send_pair(0, 0, COORD_MIN, 0, 0, 0, COORD_MAX, 0);
        // A 300/400/500 triangle: exact touching, then one LSB of clearance.
        send_pair(0, 0, 0, 200, 300, 400, 0, 300);
        send_pair(-150, -200, 9, 200, 150, 200, 9, 299);
        // sqrt(18) is about 4.24, so radii of 2 and 2 leave less than one LSB.
        send_pair(3, 3, 0, 2, 0, 0, 0, 2);
        send_pair(1, 1, 1, 0, 0, 0, 0, 0);
        send_pair(-1, -1, -1, 0, 0, 0, 0, 1);
        send_pair(coord_t'(20'h55555), coord_t'(20'hAAAAA), coord_t'(20'h55555),
                  radius_t'(19'h2AAAA), coord_t'(20'hAAAAA), coord_t'(20'h55555),
                  coord_t'(20'hAAAAA), radius_t'(19'h55555));
        send_pair(COORD_MAX, COORD_MIN, 0, 0, COORD_MAX, COORD_MIN, COORD_MAX, RADIUS_MAX);
        finish_phase();

        // Directed pairs in planar mode: z must have no effect at all, even
        // at its extremes.
        set_planar(1'b1);
        send_pair(0, 0, COORD_MIN, 0, 0, 0, COORD_MAX, 0);
        send_pair(COORD_MAX, COORD_MAX, 7, 0, COORD_MIN, COORD_MIN, -7, 0);
        send_pair(0, 0, COORD_MAX, 200, 300, 400, COORD_MIN, 300);
        send_pair(3, 3, 1000, 2, 0, 0, -1000, 2);
        send_pair(0, 0, 0, 0, 0, 0, 0, 0);
        send_pair(12, -34, 99999, 0, 12, -34, -99999, RADIUS_MAX);
        finish_phase();

        // Random phases alternate between the two modes. The middle phase
        // runs with no holding back on either side, to stream back to back.
        for (int ph = 0; ph < 5; ph++)
        begin
            set_planar(ph % 2 == 1);
            idle_pct = (ph == 2) ? 0 : 30;
            for (int n = 0; n < 140; n++)
                queue_pair(random_pair());
            finish_phase();
        end
        idle_pct = 30;

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && owed_results.size() == 0)
            $display("PASS sphere_pair_clearance_distance");
        else
            $display("FAIL sphere_pair_clearance_distance");
        $finish;
    end

endmodule
